[rtl/core/ppu_pkg.sv]
// ppu_pkg: shared types, widths and constants of the phase pll pi update unit
// no dependencies; used by every module of the block by scoped name
`timescale 1ns / 1ps
`default_nettype none

package ppu_pkg;

  // field widths
  localparam int ERR_W    = 16;
  localparam int CONF_W   = 16;
  localparam int DT_W     = 20;
  localparam int IG_W     = 24;
  localparam int KP_W     = 16;
  localparam int MAXF_W   = 31;
  localparam int MAXP_W   = 15;
  localparam int PHASE_W  = 16;
  localparam int FREQ_W   = 32;
  localparam int CFG_W    = 31;
  localparam int CFG_IDX_W = 2;

  // packed stream widths, padded to whole bytes
  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 56;

  // shared multiplier operand and product widths
  localparam int MUL_A_W = 25;
  localparam int MUL_B_W = 21;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // intermediate widths
  localparam int IE_W    = 40;   // ki gain * error
  localparam int HALF_W  = 20;   // split point of the ie product
  localparam int LO_W    = 40;   // low half times time step
  localparam int HI_W    = 41;   // high half times time step
  localparam int SUM_W   = 61;   // full ig * e * dt
  localparam int FSHIFT  = 36;
  localparam int DELTA_W = SUM_W - FSHIFT;
  localparam int KPE_W   = 33;   // kp gain * error
  localparam int PSHIFT  = 12;
  localparam int PSTEP_W = KPE_W - PSHIFT;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_KI_GAIN        = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KP_GAIN        = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_FREQ_CORR  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_PHASE_STEP = 2'd3;

  // register reset values
  localparam logic [IG_W-1:0]   IG_RESET   = 24'd65536;
  localparam logic [KP_W-1:0]   KP_RESET   = 16'd4096;
  localparam logic [MAXF_W-1:0] MAXF_RESET = 31'd655360;
  localparam logic [MAXP_W-1:0] MAXP_RESET = 15'd32767;

  // measurement quality thresholds
  localparam logic [CONF_W-1:0]       CONF_REJECT = 16'd29492;  // 0.45
  localparam logic [CONF_W-1:0]       CONF_GOOD   = 16'd45875;  // 0.7
  localparam logic signed [ERR_W-1:0] ERR_GOOD    = 16'sd1669;  // 0.16 rad

  // lock and reject counters
  localparam logic [3:0] LOCK_COUNT = 4'd8;
  localparam logic [2:0] BAD_MAX    = 3'd4;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_IE,
    ST_LO,
    ST_HI,
    ST_KP,
    ST_FIN,
    ST_WRITE
  } state_t;

  // shared multiplier operand select
  typedef enum logic [1:0] {
    MUL_IE,
    MUL_LO,
    MUL_HI,
    MUL_KP
  } mul_sel_t;

  // sequencer to datapath control
  typedef struct packed {
    logic     accept;
    mul_sel_t sel;
    logic     cap_ie;
    logic     cap_lo;
    logic     cap_hi;
    logic     fin;
    logic     write;
  } ctrl_t;

endpackage

`default_nettype wire

[rtl/core/ppu_mult.sv]
// ppu_mult: shared signed multiplier with a registered product
// depends on ppu_pkg for operand widths
`timescale 1ns / 1ps
`default_nettype none

module ppu_mult (
  input  wire logic                               clk,
  input  wire logic signed [ppu_pkg::MUL_A_W-1:0] a,
  input  wire logic signed [ppu_pkg::MUL_B_W-1:0] b,
  output logic signed [ppu_pkg::MUL_P_W-1:0]      p
);

  // one product per cycle, result registered for the next cycle
  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

`default_nettype wire

[rtl/core/ppu_ctrl.sv]
// ppu_ctrl: sequencer that walks one measurement through the shared multiplier
// depends on ppu_pkg for state_t, mul_sel_t and ctrl_t
`timescale 1ns / 1ps
`default_nettype none

module ppu_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  input  wire logic           reject,
  input  wire logic           out_free,
  output logic                in_ready,
  output ppu_pkg::ctrl_t      ctrl
);

  ppu_pkg::state_t state;
  ppu_pkg::state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ppu_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ppu_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = reject ? ppu_pkg::ST_WRITE : ppu_pkg::ST_IE;
        end
      end
      ppu_pkg::ST_IE:  state_next = ppu_pkg::ST_LO;
      ppu_pkg::ST_LO:  state_next = ppu_pkg::ST_HI;
      ppu_pkg::ST_HI:  state_next = ppu_pkg::ST_KP;
      ppu_pkg::ST_KP:  state_next = ppu_pkg::ST_FIN;
      ppu_pkg::ST_FIN: state_next = ppu_pkg::ST_WRITE;
      ppu_pkg::ST_WRITE: begin
        if (out_free) begin
          state_next = ppu_pkg::ST_IDLE;
        end
      end
      default: state_next = ppu_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready    = 1'b0;
    ctrl.accept = 1'b0;
    ctrl.sel    = ppu_pkg::MUL_IE;
    ctrl.cap_ie = 1'b0;
    ctrl.cap_lo = 1'b0;
    ctrl.cap_hi = 1'b0;
    ctrl.fin    = 1'b0;
    ctrl.write  = 1'b0;
    case (state)
      ppu_pkg::ST_IDLE: begin
        in_ready    = 1'b1;
        ctrl.accept = in_valid;
      end
      ppu_pkg::ST_IE: ctrl.sel = ppu_pkg::MUL_IE;
      ppu_pkg::ST_LO: begin
        ctrl.sel    = ppu_pkg::MUL_LO;
        ctrl.cap_ie = 1'b1;
      end
      ppu_pkg::ST_HI: begin
        ctrl.sel    = ppu_pkg::MUL_HI;
        ctrl.cap_lo = 1'b1;
      end
      ppu_pkg::ST_KP: begin
        ctrl.sel    = ppu_pkg::MUL_KP;
        ctrl.cap_hi = 1'b1;
      end
      ppu_pkg::ST_FIN:   ctrl.fin   = 1'b1;
      ppu_pkg::ST_WRITE: ctrl.write = out_free;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

[rtl/core/phase_pll_pi_update_unit.sv]
// phase_pll_pi_update_unit: pi loop filter with lock detect for a digital pll
// depends on ppu_pkg, ppu_ctrl and ppu_mult
//
// channel   dir  handshake                      contents
// s_axis    in   s_axis_tvalid / s_axis_tready  phase_error, confidence, time_step
// m_axis    out  m_axis_tvalid / m_axis_tready  phase_correction, frequency_correction, locked
// cfg       in   cfg_we                         cfg_index, cfg_data
//
// a beat that is not rejected passes through the ie, lo, hi, kp, fin and write steps to
// the output register, and the next beat is accepted only back in idle; the four products
// share one 25x21 multiplier, one per cycle; a rejected measurement skips the multiplier
// and goes from idle straight to the write step; the output register holds a result
// while the next beat is accepted; a stalled output holds the sequencer in its write step
// rst is synchronous: accumulators and counters clear, registers take defaults
`timescale 1ns / 1ps
`default_nettype none

module phase_pll_pi_update_unit (
  input  wire logic                               clk,
  input  wire logic                               rst,
  // phase_error [15:0], confidence [31:16], time_step [51:32], zero [55:52]
  input  wire logic [ppu_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  // phase_correction [15:0], frequency_correction [47:16], locked [48], zero [55:49]
  output logic [ppu_pkg::OUT_TDATA_W-1:0]         m_axis_tdata,
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  input  wire logic                               cfg_we,
  input  wire logic [ppu_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [ppu_pkg::CFG_W-1:0]          cfg_data
);

  // configuration registers
  logic [ppu_pkg::IG_W-1:0]   ki_gain;
  logic [ppu_pkg::KP_W-1:0]   kp_gain;
  logic [ppu_pkg::MAXF_W-1:0] max_frequency_correction;
  logic [ppu_pkg::MAXP_W-1:0] max_phase_step;

  // loop state
  logic [ppu_pkg::PHASE_W-1:0]        phase_accum;
  logic signed [ppu_pkg::FREQ_W-1:0]  freq_accum;
  logic [3:0]                         good_count;
  logic [2:0]                         bad_count;

  // captured beat
  logic signed [ppu_pkg::ERR_W-1:0] err;
  logic [ppu_pkg::DT_W-1:0]         dt;
  logic                             rej;
  logic                             good;

  // intermediate products and terms
  logic signed [ppu_pkg::IE_W-1:0]    p_ie;
  logic [ppu_pkg::LO_W-1:0]           p_lo;
  logic signed [ppu_pkg::HI_W-1:0]    p_hi;
  logic signed [ppu_pkg::DELTA_W-1:0] delta;
  logic signed [ppu_pkg::PHASE_W-1:0] step;

  // output register
  logic [ppu_pkg::PHASE_W-1:0] out_phase;
  logic [ppu_pkg::FREQ_W-1:0]  out_freq;
  logic                        out_locked;
  logic                        out_valid;

  // input field views
  logic signed [ppu_pkg::ERR_W-1:0] in_err;
  logic [ppu_pkg::CONF_W-1:0]       in_conf;
  logic [ppu_pkg::DT_W-1:0]         in_dt;
  logic                             in_reject;
  logic                             in_good;

  ppu_pkg::ctrl_t ctrl;
  logic           out_free;

  logic signed [ppu_pkg::MUL_A_W-1:0] mul_a;
  logic signed [ppu_pkg::MUL_B_W-1:0] mul_b;
  logic signed [ppu_pkg::MUL_P_W-1:0] mul_p;

  assign in_err  = s_axis_tdata[15:0];
  assign in_conf = s_axis_tdata[31:16];
  assign in_dt   = s_axis_tdata[51:32];

  // measurement quality at the input
  assign in_reject = (in_dt == '0) || (in_conf < ppu_pkg::CONF_REJECT);
  assign in_good   = (in_err > -ppu_pkg::ERR_GOOD) && (in_err < ppu_pkg::ERR_GOOD) &&
                     (in_conf > ppu_pkg::CONF_GOOD);

  assign out_free = !out_valid || m_axis_tready;

  ppu_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .reject   (in_reject),
    .out_free (out_free),
    .in_ready (s_axis_tready),
    .ctrl     (ctrl)
  );

  // operand select for the shared multiplier
  always_comb begin
    case (ctrl.sel)
      ppu_pkg::MUL_IE: begin
        mul_a = {1'b0, ki_gain};
        mul_b = {{(ppu_pkg::MUL_B_W-ppu_pkg::ERR_W){err[ppu_pkg::ERR_W-1]}}, err};
      end
      ppu_pkg::MUL_LO: begin
        mul_a = {{(ppu_pkg::MUL_A_W-ppu_pkg::HALF_W){1'b0}}, mul_p[ppu_pkg::HALF_W-1:0]};
        mul_b = {1'b0, dt};
      end
      ppu_pkg::MUL_HI: begin
        mul_a = {{(ppu_pkg::MUL_A_W-ppu_pkg::HALF_W){p_ie[ppu_pkg::IE_W-1]}},
                 p_ie[ppu_pkg::IE_W-1:ppu_pkg::HALF_W]};
        mul_b = {1'b0, dt};
      end
      ppu_pkg::MUL_KP: begin
        mul_a = {{(ppu_pkg::MUL_A_W-ppu_pkg::KP_W){1'b0}}, kp_gain};
        mul_b = {{(ppu_pkg::MUL_B_W-ppu_pkg::ERR_W){err[ppu_pkg::ERR_W-1]}}, err};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  ppu_mult u_mult (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      ki_gain                  <= ppu_pkg::IG_RESET;
      kp_gain                  <= ppu_pkg::KP_RESET;
      max_frequency_correction <= ppu_pkg::MAXF_RESET;
      max_phase_step           <= ppu_pkg::MAXP_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        ppu_pkg::REG_KI_GAIN:        ki_gain        <= cfg_data[ppu_pkg::IG_W-1:0];
        ppu_pkg::REG_KP_GAIN:        kp_gain        <= cfg_data[ppu_pkg::KP_W-1:0];
        ppu_pkg::REG_MAX_FREQ_CORR:  max_frequency_correction <= cfg_data;
        ppu_pkg::REG_MAX_PHASE_STEP: max_phase_step <= cfg_data[ppu_pkg::MAXP_W-1:0];
        default: ;
      endcase
    end
  end

  // capture the beat and the partial products
  always_ff @(posedge clk) begin
    if (ctrl.accept) begin
      err  <= in_err;
      dt   <= in_dt;
      rej  <= in_reject;
      good <= in_good;
    end
    if (ctrl.cap_ie) p_ie <= mul_p[ppu_pkg::IE_W-1:0];
    if (ctrl.cap_lo) p_lo <= mul_p[ppu_pkg::LO_W-1:0];
    if (ctrl.cap_hi) p_hi <= mul_p[ppu_pkg::HI_W-1:0];
  end

  // full integral product and proportional step
  logic signed [ppu_pkg::SUM_W-1:0]   sum_full;
  logic signed [ppu_pkg::PSTEP_W-1:0] step_raw;
  logic signed [ppu_pkg::PSTEP_W-1:0] step_lim;

  assign sum_full = $signed({p_hi, {ppu_pkg::HALF_W{1'b0}}}) +
                    $signed({{(ppu_pkg::SUM_W-ppu_pkg::LO_W){1'b0}}, p_lo});
  assign step_raw = mul_p[ppu_pkg::KPE_W-1:ppu_pkg::PSHIFT];
  assign step_lim = $signed({{(ppu_pkg::PSTEP_W-ppu_pkg::MAXP_W){1'b0}}, max_phase_step});

  always_ff @(posedge clk) begin
    if (ctrl.fin) begin
      delta <= sum_full[ppu_pkg::SUM_W-1:ppu_pkg::FSHIFT];
      if (step_raw > step_lim) begin
        step <= step_lim[ppu_pkg::PHASE_W-1:0];
      end else if (step_raw < -step_lim) begin
        step <= ppu_pkg::PHASE_W'(-step_lim);
      end else begin
        step <= step_raw[ppu_pkg::PHASE_W-1:0];
      end
    end
  end

  // saturating frequency update and lock counting
  logic signed [ppu_pkg::FREQ_W:0] freq_sum;
  logic signed [ppu_pkg::FREQ_W:0] freq_lim;
  logic signed [ppu_pkg::FREQ_W-1:0] freq_next;
  logic [ppu_pkg::PHASE_W-1:0]       phase_next;
  logic [3:0]                        good_next;
  logic [2:0]                        bad_next;

  assign freq_sum = $signed({freq_accum[ppu_pkg::FREQ_W-1], freq_accum}) +
                    $signed({{(ppu_pkg::FREQ_W+1-ppu_pkg::DELTA_W){delta[ppu_pkg::DELTA_W-1]}},
                             delta});
  assign freq_lim = $signed({2'b00, max_frequency_correction});

  always_comb begin
    freq_next  = freq_accum;
    phase_next = phase_accum;
    good_next  = good_count;
    bad_next   = bad_count;
    if (rej) begin
      good_next = '0;
      if (bad_count < ppu_pkg::BAD_MAX) bad_next = bad_count + 3'd1;
    end else begin
      if (freq_sum > freq_lim) begin
        freq_next = freq_lim[ppu_pkg::FREQ_W-1:0];
      end else if (freq_sum < -freq_lim) begin
        freq_next = ppu_pkg::FREQ_W'(-freq_lim);
      end else begin
        freq_next = freq_sum[ppu_pkg::FREQ_W-1:0];
      end
      phase_next = phase_accum + step;
      if (good) begin
        bad_next = '0;
        if (good_count < ppu_pkg::LOCK_COUNT) good_next = good_count + 4'd1;
      end else begin
        good_next = '0;
      end
    end
  end

  // loop state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_accum <= '0;
      freq_accum  <= '0;
      good_count  <= '0;
      bad_count   <= '0;
    end else if (ctrl.write) begin
      phase_accum <= phase_next;
      freq_accum  <= freq_next;
      good_count  <= good_next;
      bad_count   <= bad_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.write) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.write) begin
      out_phase  <= phase_next;
      out_freq   <= freq_next;
      out_locked <= !rej && (good_next >= ppu_pkg::LOCK_COUNT);
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {7'd0, out_locked, out_freq, out_phase};

endmodule

`default_nettype wire

[rtl/core/ppu_checker.sv]
// ppu_checker: port-level checks of the phase pll pi update unit, with its bind
// depends on ppu_pkg for stream widths
`timescale 1ns / 1ps
`default_nettype none

module ppu_checker (
  input wire logic                               clk,
  input wire logic                               rst,
  input wire logic                               s_axis_tvalid,
  input wire logic                               s_axis_tready,
  input wire logic [ppu_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  input wire logic                               m_axis_tvalid,
  input wire logic                               m_axis_tready
);

  // a stalled result beat holds its data
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

  // one beat at a time: an accepted beat closes the input
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input still ready after an accepted beat");

  // a new result appears as the sequencer returns to idle
  a_result_frees_input: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> s_axis_tready)
    else $error("result appeared while input still busy");

  // reset empties the output register
  a_reset_clears: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

endmodule

bind phase_pll_pi_update_unit ppu_checker u_ppu_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready)
);

`default_nettype wire

[verif/phase_pll_pi_update_unit_tb.sv]
// phase_pll_pi_update_unit_tb: self-checking bench for the pll pi update unit
// drives measurement beats and register writes, predicts every correction beat
// depends on ppu_pkg and phase_pll_pi_update_unit
`timescale 1ns / 1ps

module phase_pll_pi_update_unit_tb;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int SETTLE_CYCLES = 12;

  typedef struct packed {
    logic [15:0]        phase;
    logic signed [31:0] freq;
    logic               locked;
  } pll_result_t;

  logic clk;
  logic rst;
  logic [ppu_pkg::IN_TDATA_W-1:0]  s_axis_tdata;
  logic                            s_axis_tvalid;
  logic                            s_axis_tready;
  logic [ppu_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready;
  logic                            cfg_we;
  logic [ppu_pkg::CFG_IDX_W-1:0]   cfg_index;
  logic [ppu_pkg::CFG_W-1:0]       cfg_data;

  // loop filter copy: registers and accumulated state
  logic [ppu_pkg::IG_W-1:0]   ki_gain;
  logic [ppu_pkg::KP_W-1:0]   kp_gain;
  logic [ppu_pkg::MAXF_W-1:0] freq_limit;
  logic [ppu_pkg::MAXP_W-1:0] phase_limit;
  logic [15:0]                phase_acc;
  logic signed [31:0]         freq_acc;
  int                         good_run;
  int                         bad_run;

  pll_result_t pending_corrections[$];
  int          fail_count;
  int          cycle_count;
  int          sink_hold;
  bit          send_idle;
  bit          sink_idle;

  phase_pll_pi_update_unit dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // run-away guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void reset_loop_model();
    ki_gain = ppu_pkg::IG_RESET;
    kp_gain = ppu_pkg::KP_RESET;
    freq_limit = ppu_pkg::MAXF_RESET;
    phase_limit = ppu_pkg::MAXP_RESET;
    phase_acc = '0;
    freq_acc = '0;
    good_run = 0;
    bad_run = 0;
  endfunction

  // one pi update: saturating integral, clamped wrapping proportional, lock count
  function automatic pll_result_t predict_pll_update(logic signed [15:0] err,
                                                     logic [15:0] conf, logic [19:0] dt);
    longint e_l, ki_l, kp_l, dt_l, flim, plim, delta, fsum, step, mag;
    pll_result_t r;
    e_l = err;
    ki_l = ki_gain;
    kp_l = kp_gain;
    dt_l = dt;
    flim = freq_limit;
    plim = phase_limit;
    if (dt == 0 || conf < ppu_pkg::CONF_REJECT) begin
      if (bad_run < 4) bad_run++;
      good_run = 0;
      r.locked = 1'b0;
    end else begin
      delta = (ki_l * e_l * dt_l) >>> 36;
      fsum = longint'(freq_acc) + delta;
      if (fsum > flim) fsum = flim;
      if (fsum < -flim) fsum = -flim;
      freq_acc = fsum[31:0];
      step = (kp_l * e_l) >>> 12;
      if (step > plim) step = plim;
      if (step < -plim) step = -plim;
      phase_acc = phase_acc + step[15:0];
      mag = (e_l < 0) ? -e_l : e_l;
      if (mag < 1669 && conf > ppu_pkg::CONF_GOOD) begin
        if (good_run < 8) good_run++;
        bad_run = 0;
      end else begin
        good_run = 0;
      end
      r.locked = (good_run >= 8);
    end
    r.phase = phase_acc;
    r.freq = freq_acc;
    return r;
  endfunction

  // one measurement beat, prediction queued at the accepting edge
  task automatic send_measurement(logic signed [15:0] err, logic [15:0] conf, logic [19:0] dt);
    int gap;
    gap = send_idle ? pick_gap() : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {4'b0, dt, conf, err};
    do @(posedge clk); while (!s_axis_tready);
    pending_corrections.push_back(predict_pll_update(err, conf, dt));
  endtask

  // stop sending and let every correction drain
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_corrections.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [ppu_pkg::CFG_IDX_W-1:0] idx, logic [ppu_pkg::CFG_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    case (idx)
      ppu_pkg::REG_KI_GAIN:        ki_gain = value[ppu_pkg::IG_W-1:0];
      ppu_pkg::REG_KP_GAIN:        kp_gain = value[ppu_pkg::KP_W-1:0];
      ppu_pkg::REG_MAX_FREQ_CORR:  freq_limit = value[ppu_pkg::MAXF_W-1:0];
      ppu_pkg::REG_MAX_PHASE_STEP: phase_limit = value[ppu_pkg::MAXP_W-1:0];
      default: ;
    endcase
  endtask

  // all four registers, written only with nothing in flight
  task automatic load_loop_config(logic [30:0] ki, logic [30:0] kp, logic [30:0] fl,
                                  logic [30:0] pl);
    wait_idle();
    write_reg(ppu_pkg::REG_KI_GAIN, ki);
    write_reg(ppu_pkg::REG_KP_GAIN, kp);
    write_reg(ppu_pkg::REG_MAX_FREQ_CORR, fl);
    write_reg(ppu_pkg::REG_MAX_PHASE_STEP, pl);
    cfg_we <= 1'b0;
  endtask

  task automatic send_good_run(int n);
    int v;
    repeat (n) begin
      v = $urandom_range(0, 2 * 1668);
      send_measurement(16'(v - 1668), 16'($urandom_range(45876, 65535)),
                       20'($urandom_range(1, 1048575)));
    end
  endtask

  // field extremes, rejection edges, good-update edges, most negative error
  task automatic test_field_extremes();
    send_idle = 1'b1;
    sink_idle = 1'b1;
    send_measurement(16'sd0, 16'd65535, 20'd1);
    send_measurement(16'sd32767, 16'd65535, 20'd1048575);
    send_measurement(-16'sd32768, 16'd65535, 20'd1048575);
    send_measurement(-16'sd32768, 16'd30000, 20'd1);
    send_measurement(-16'sd1, 16'd65535, 20'd1);
    send_measurement(16'sd1, 16'd65535, 20'd524288);
    send_measurement(16'sd100, 16'd65535, 20'd0);
    send_measurement(16'sd100, 16'd29491, 20'd1000);
    send_measurement(16'sd100, 16'd0, 20'd1000);
    send_measurement(16'sd100, 16'd29492, 20'd1000);
    send_measurement(16'sd100, 16'd45875, 20'd1000);
    send_measurement(16'sd100, 16'd45876, 20'd1000);
    send_measurement(16'sd1668, 16'd65535, 20'd4096);
    send_measurement(-16'sd1668, 16'd65535, 20'd4096);
    send_measurement(16'sd1669, 16'd65535, 20'd4096);
    send_measurement(-16'sd1669, 16'd65535, 20'd4096);
    // a run of rejections saturates the reject counter
    repeat (6) send_measurement(16'sd5, 16'd65535, 20'd0);
    send_measurement(-16'sd12345, 16'd50000, 20'd777777);
  endtask

  // lock after eight good updates, held while good, lost on a bad or rejected one
  task automatic test_lock_detect();
    load_loop_config(31'd65536, 31'd4096, 31'd655360, 31'd32767);
    send_good_run(12);
    send_measurement(16'sd2000, 16'd65535, 20'd1000);
    send_good_run(8);
    send_measurement(16'sd10, 16'd65535, 20'd0);
    send_good_run(9);
    send_measurement(16'sd10, 16'd40000, 20'd1000);
    send_good_run(7);
    send_measurement(16'sd10, 16'd100, 20'd1000);
  endtask

  // every register at its top and at zero
  task automatic test_gain_extremes();
    load_loop_config(31'hFFFFFF, 31'hFFFF, 31'h7FFFFFFF, 31'h7FFF);
    send_measurement(16'sd32767, 16'd65535, 20'd1048575);
    send_measurement(-16'sd32768, 16'd65535, 20'd1048575);
    send_measurement(-16'sd1, 16'd65535, 20'd1);
    send_measurement(16'sd1, 16'd65535, 20'd1);
    send_good_run(4);
    load_loop_config(31'd0, 31'd0, 31'd0, 31'd0);
    send_measurement(16'sd32767, 16'd65535, 20'd1048575);
    send_measurement(-16'sd32768, 16'd65535, 20'd1048575);
    send_good_run(9);
    load_loop_config(31'hFFFFFF, 31'hFFFF, 31'd1, 31'd1);
    send_measurement(16'sd32767, 16'd65535, 20'd1048575);
    send_measurement(-16'sd32768, 16'd65535, 20'd1048575);
    send_measurement(-16'sd1, 16'd65535, 20'd1);
  endtask

  // drive the integral into its widest rail, then walk back
  task automatic test_freq_saturation();
    load_loop_config(31'hFFFFFF, 31'd4096, 31'h7FFFFFFF, 31'd32767);
    send_idle = 1'b0;
    sink_idle = 1'b0;
    repeat (264) send_measurement(16'sd32767, 16'd65535, 20'd1048575);
    repeat (16) send_measurement(-16'sd32768, 16'd65535, 20'd1048575);
    load_loop_config(31'hFFFFFF, 31'd4096, 31'd5000, 31'd100);
    send_idle = 1'b1;
    repeat (10) send_measurement(-16'sd32768, 16'd65535, 20'd1048575);
    repeat (10) send_measurement(16'sd32767, 16'd65535, 20'd1048575);
  endtask

  // mostly plausible measurement streams with lock runs, some rejections and noise
  task automatic send_random_burst(int n);
    int sent;
    int r;
    int len;
    sent = 0;
    while (sent < n) begin
      r = $urandom_range(0, 99);
      if (r < 40) begin
        len = $urandom_range(1, 12);
        send_good_run(len);
        sent += len;
      end else if (r < 70) begin
        send_measurement(16'($urandom()), 16'($urandom_range(29492, 65535)),
                         ($urandom_range(0, 3) == 0) ? 20'($urandom_range(1, 64))
                                                     : 20'($urandom_range(1, 1048575)));
        sent++;
      end else if (r < 78) begin
        send_measurement(16'($urandom()), 16'($urandom()), 20'd0);
        sent++;
      end else if (r < 85) begin
        send_measurement(16'($urandom()), 16'($urandom_range(0, 29491)), 20'($urandom()));
        sent++;
      end else begin
        send_measurement(16'($urandom()), 16'($urandom()), 20'($urandom()));
        sent++;
      end
    end
  endtask

  task automatic test_random_traffic();
    // default settings
    load_loop_config(31'd65536, 31'd4096, 31'd655360, 31'd32767);
    send_idle = 1'($urandom_range(0, 1));
    sink_idle = 1'b1;
    send_random_burst(230);
    // raw random register data, upper bits beyond each width included
    load_loop_config(31'($urandom()), 31'($urandom()), 31'($urandom()), 31'($urandom()));
    send_idle = 1'b1;
    sink_idle = 1'($urandom_range(0, 1));
    send_random_burst(230);
    // small limits keep both clamps busy
    load_loop_config(31'($urandom_range(0, 16777215)), 31'($urandom_range(0, 65535)),
                     31'($urandom_range(0, 200000)), 31'($urandom_range(0, 600)));
    send_idle = 1'b1;
    sink_idle = 1'b1;
    send_random_burst(230);
    // wide limits and random gains
    load_loop_config(31'($urandom_range(0, 16777215)), 31'($urandom_range(0, 65535)),
                     31'h7FFFFFFF, 31'h7FFF);
    send_idle = 1'b0;
    sink_idle = 1'b1;
    send_random_burst(230);
  endtask

  // sink side readiness with random stalls
  initial begin
    m_axis_tready <= 1'b0;
    sink_hold = 0;
    forever begin
      @(posedge clk);
      if (sink_hold > 0) begin
        sink_hold--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (sink_idle && $urandom_range(0, 3) == 0) sink_hold = pick_gap();
      end
    end
  end

  // compare each correction beat with the oldest prediction
  always @(posedge clk) begin
    pll_result_t exp_r;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_corrections.size() == 0) begin
        $error("correction beat with no pending prediction: %h", m_axis_tdata);
        fail_count++;
      end else begin
        exp_r = pending_corrections.pop_front();
        if (m_axis_tdata[15:0] !== exp_r.phase) begin
          $error("phase_correction mismatch: expected %0d, got %0d",
                 $signed(exp_r.phase), $signed(m_axis_tdata[15:0]));
          fail_count++;
        end
        if (m_axis_tdata[47:16] !== exp_r.freq) begin
          $error("frequency_correction mismatch: expected %0d, got %0d",
                 exp_r.freq, $signed(m_axis_tdata[47:16]));
          fail_count++;
        end
        if (m_axis_tdata[48] !== exp_r.locked) begin
          $error("locked mismatch: expected %0d, got %0d", exp_r.locked, m_axis_tdata[48]);
          fail_count++;
        end
      end
    end
  end

  initial begin
    fail_count = 0;
    cycle_count = 0;
    send_idle = 1'b0;
    sink_idle = 1'b0;
    reset_loop_model();
    rst <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    cfg_we <= 1'b0;
    cfg_index <= ppu_pkg::REG_KI_GAIN;
    cfg_data <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_field_extremes();
    test_lock_detect();
    test_gain_extremes();
    test_freq_saturation();
    test_random_traffic();

    wait_idle();
    if (fail_count == 0 && pending_corrections.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
